[src/shs_pkg.sv]
// shared types and constants for the successive halving scheduler
package shs_pkg;

  localparam int HANDLE_W  = 10;
  localparam int STAGE_W   = 4;
  localparam int TIME_W    = 32;
  localparam int IN_SCORE_W = 32;
  localparam logic [STAGE_W-1:0] STAGE_MAX = 4'd15;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_START  = 2'd1,
    ACT_NEXT   = 2'd2,
    ACT_UPDATE = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FINISHED = 2'd1,
    ST_FULL     = 2'd2,
    ST_REJECT   = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_END_TIME = 1'b0,
    CFG_INTERVAL = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    cmd_e_t                  kind;
    logic [IN_SCORE_W-1:0]   score;
    logic [TIME_W-1:0]       now;
  } cmd_t;

  typedef struct packed {
    status_t                 status;
    logic [HANDLE_W-1:0]     id;
    logic [IN_SCORE_W-1:0]   score;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EXEC,
    S_LOG,
    S_LEN_DIV,
    S_MODIV,
    S_CHK,
    S_BOUND,
    S_SORT_I,
    S_SORT_KEY,
    S_SORT_J,
    S_SORT_CMP,
    S_SORT_END,
    S_POS_GO,
    S_POS,
    S_POS_RD,
    S_FIN_RD,
    S_UPD_RD,
    S_UPD_WR,
    S_OUT
  } eng_state_t;

endpackage

[src/successive_halving_scheduler.sv]
// top level of the successive halving scheduler
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  in_      | tvalid / tready    | tuser: action; tdata: score, now_time
//  out_     | tvalid / tready    | tdata: status, entry_id, entry_score, stage
//  cfg_     | we (no wait)       | idx 0 end_time, idx 1 refresh_interval
//
// engine: one request at a time, from the pop to the result register; next and
// start use the shared divider (start does not when end_time is already past);
// a halving stage adds an insertion sort over the table in memory
// reset: synchronous active-low; the table memory needs no clearing pass
// stalls: a request register and a two-deep queue let the input side keep
// taking requests while the engine works; the engine holds its result while
// the output register is still full
module successive_halving_scheduler import shs_pkg::*; #(
  parameter int MAX_ENTRIES = 1024,
  parameter int SCORE_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // score[31:0], now_time[63:32]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status[1:0], entry_id[11:2], entry_score[43:12], stage[47:44]
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_data
);

  logic push_valid, push_ready, q_valid, q_pop;
  cmd_t push_cmd, q_cmd;
  res_t res;
  logic [STAGE_W-1:0] res_stage;

  // request register and action decode
  shs_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_action(in_tuser), .in_score(in_tdata[31:0]), .in_now(in_tdata[63:32]),
    .push_valid(push_valid), .push_ready(push_ready), .push_cmd(push_cmd)
  );

  // decoupling queue
  shs_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_ready(push_ready), .push_cmd(push_cmd),
    .pop_valid(q_valid), .pop(q_pop), .pop_cmd(q_cmd)
  );

  // table, stage control and result register
  shs_engine #(
    .MAX_ENTRIES(MAX_ENTRIES), .SCORE_BITS(SCORE_BITS)
  ) u_engine (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_res(res), .out_stage(res_stage)
  );

  assign out_tdata = {res_stage, res.score, res.id, res.status};

endmodule

[src/shs_front.sv]
// input stage: takes requests, classifies the action and pushes them to the queue
module shs_front import shs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_score,
  input  logic [31:0] in_now,
  output logic        push_valid,
  input  logic        push_ready,
  output cmd_t        push_cmd
);

  logic valid_r, valid_nxt;
  cmd_t cmd_r, cmd_nxt;

  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_cmd   = cmd_r;

  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (push_ready) valid_nxt = 1'b0;
    if (in_valid && in_ready) begin
      valid_nxt     = 1'b1;
      // every 2-bit code is a valid action
      cmd_nxt.kind  = cmd_e_t'(in_action);
      cmd_nxt.score = in_score;
      cmd_nxt.now   = in_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
    cmd_r <= cmd_nxt;
  end

endmodule

[src/shs_queue.sv]
// two-entry request queue between front and engine
module shs_queue import shs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_cmd    = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wp_nxt  = do_push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) slot_r[wp_r] <= push_cmd;
  end

endmodule

[src/shs_divider.sv]
// shared restoring divider, one quotient bit per cycle
module shs_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot,
  output logic [31:0] rem
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [31:0] quo_r, quo_nxt, rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [32:0] shifted, trial;

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

  always_comb begin
    shifted  = {rem_r, quo_r[31]};
    trial    = shifted - {1'b0, dvs_r};
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = 6'd32;
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (cnt_r != 6'd0) begin
      cnt_nxt = cnt_r - 6'd1;
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      done_nxt = (cnt_r == 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

[src/shs_engine.sv]
// back end: candidate table, stage control, sort sequencer and result register
module shs_engine import shs_pkg::*; #(
  parameter int MAX_ENTRIES = 1024,
  parameter int SCORE_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_data,
  input  logic        q_valid,
  output logic        q_pop,
  input  cmd_t        q_cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res,
  output logic [STAGE_W-1:0] out_stage
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int EW = HANDLE_W + SCORE_BITS;

  typedef logic signed [SCORE_BITS-1:0] sc_t;

  // table memory, handle in the upper bits
  logic [EW-1:0] mem [MAX_ENTRIES];
  logic [EW-1:0] rd_data_r;
  logic [IW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [EW-1:0] wr_data;

  eng_state_t state_r, state_nxt;
  cmd_t       cur_r, cur_nxt;
  res_t       res_r, res_nxt;
  logic       ov_r, ov_nxt;
  res_t       ores_r, ores_nxt;
  logic [STAGE_W-1:0] ostage_r, ostage_nxt;

  logic [31:0] end_r, end_nxt;
  logic [15:0] iv_r, iv_nxt;
  logic [CW-1:0] live_r, live_nxt;
  logic [31:0] calls_r, calls_nxt, samp_r, samp_nxt, start_r, start_nxt, len_r, len_nxt;
  logic [STAGE_W-1:0] stage_r, stage_nxt;
  logic started_r, started_nxt, handed_r, handed_nxt;
  logic [IW-1:0] lpos_r, lpos_nxt;
  logic [CW:0]   x_r, x_nxt;
  logic [4:0]    n_r, n_nxt;
  logic [35:0]   prod_r, prod_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [EW-1:0] key_r, key_nxt;

  logic        div_start, div_done;
  logic [31:0] div_a, div_b, div_q, div_rem;

  sc_t         in_sc;
  logic [31:0] in_sc32;
  sc_t         rd_sc, key_sc;
  logic [31:0] rd_sc32;
  logic [36:0] bound;

  shs_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quot(div_q), .rem(div_rem)
  );

  assign out_valid = ov_r;
  assign out_res   = ores_r;
  assign out_stage = ostage_r;

  always_comb begin
    // the 32-bit field is taken as raw bits and reinterpreted at the score width
    in_sc   = SCORE_BITS'(cur_r.score);
    in_sc32 = 32'(in_sc);
    rd_sc   = rd_data_r[SCORE_BITS-1:0];
    rd_sc32 = 32'(rd_sc);
    key_sc  = key_r[SCORE_BITS-1:0];
    bound   = 37'(start_r) + 37'(prod_r);
  end

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    res_nxt     = res_r;
    ov_nxt      = ov_r;
    ores_nxt    = ores_r;
    ostage_nxt  = ostage_r;
    end_nxt     = end_r;
    iv_nxt      = iv_r;
    live_nxt    = live_r;
    calls_nxt   = calls_r;
    samp_nxt    = samp_r;
    start_nxt   = start_r;
    len_nxt     = len_r;
    stage_nxt   = stage_r;
    started_nxt = started_r;
    handed_nxt  = handed_r;
    lpos_nxt    = lpos_r;
    x_nxt       = x_r;
    n_nxt       = n_r;
    prod_nxt    = prod_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    key_nxt     = key_r;
    q_pop       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    div_start   = 1'b0;
    div_a       = calls_r;
    div_b       = 32'd1;

    if (ov_r && out_ready) ov_nxt = 1'b0;

    if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_END_TIME: end_nxt = cfg_data;
        CFG_INTERVAL: iv_nxt  = cfg_data[15:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_cmd;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt   = '{ST_REJECT, '0, '0};
        state_nxt = S_OUT;
        case (cur_r.kind)
          ACT_LOAD: begin
            if (started_r) begin
              res_nxt = '{ST_REJECT, '0, '0};
            end else if (32'(live_r) >= 32'(MAX_ENTRIES)) begin
              res_nxt = '{ST_FULL, '0, '0};
            end else begin
              wr_en    = 1'b1;
              wr_addr  = IW'(live_r);
              wr_data  = {HANDLE_W'(live_r), in_sc};
              live_nxt = live_r + CW'(1);
              res_nxt  = '{ST_OK, HANDLE_W'(live_r), in_sc32};
            end
          end
          ACT_START: begin
            if (!started_r && live_r != '0) begin
              x_nxt     = (CW+1)'(1);
              n_nxt     = 5'd1;
              state_nxt = S_LOG;
            end
          end
          ACT_NEXT: begin
            if (started_r) begin
              div_start = 1'b1;
              div_a     = calls_r;
              div_b     = (iv_r == 16'd0) ? 32'd1 : 32'(iv_r);
              state_nxt = S_MODIV;
            end
          end
          default: begin
            if (handed_r && CW'(lpos_r) < live_r) begin
              rd_addr   = lpos_r;
              state_nxt = S_UPD_RD;
            end
          end
        endcase
      end
      // 1 + ceil(log2 count), one doubling per cycle
      S_LOG: begin
        if (x_r < (CW+1)'(live_r)) begin
          x_nxt = x_r << 1;
          n_nxt = n_r + 5'd1;
        end else begin
          start_nxt   = cur_r.now;
          samp_nxt    = cur_r.now;
          started_nxt = 1'b1;
          res_nxt     = '{ST_OK, '0, '0};
          if (end_r > cur_r.now) begin
            div_start = 1'b1;
            div_a     = end_r - cur_r.now;
            div_b     = 32'(n_r);
            state_nxt = S_LEN_DIV;
          end else begin
            len_nxt   = '0;
            state_nxt = S_OUT;
          end
        end
      end
      S_LEN_DIV: begin
        if (div_done) begin
          len_nxt   = div_q;
          state_nxt = S_OUT;
        end
      end
      S_MODIV: begin
        if (div_done) begin
          if (div_rem == 32'd0) samp_nxt = cur_r.now;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        rd_addr  = '0;
        prod_nxt = 36'(len_r) * 36'(5'(stage_r) + 5'd1);
        if (samp_r >= end_r) begin
          handed_nxt = 1'b0;
          state_nxt  = S_FIN_RD;
        end else if (stage_r < STAGE_MAX) begin
          state_nxt = S_BOUND;
        end else begin
          state_nxt = S_POS_GO;
        end
      end
      S_FIN_RD: begin
        res_nxt   = '{ST_FINISHED, rd_data_r[EW-1:SCORE_BITS], '0};
        state_nxt = S_OUT;
      end
      S_BOUND: begin
        if (37'(samp_r) >= bound) begin
          i_nxt     = CW'(1);
          state_nxt = S_SORT_I;
        end else begin
          state_nxt = S_POS_GO;
        end
      end
      // insertion sort over the table, one memory access a cycle
      S_SORT_I: begin
        if (i_r >= live_r) begin
          state_nxt = S_SORT_END;
        end else begin
          rd_addr   = IW'(i_r);
          state_nxt = S_SORT_KEY;
        end
      end
      S_SORT_KEY: begin
        key_nxt   = rd_data_r;
        j_nxt     = i_r;
        state_nxt = S_SORT_J;
      end
      S_SORT_J: begin
        if (j_r == '0) begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          wr_data   = key_r;
          i_nxt     = i_r + CW'(1);
          state_nxt = S_SORT_I;
        end else begin
          rd_addr   = IW'(j_r - CW'(1));
          state_nxt = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        wr_en   = 1'b1;
        wr_addr = IW'(j_r);
        if (rd_sc > key_sc) begin
          wr_data   = rd_data_r;
          j_nxt     = j_r - CW'(1);
          state_nxt = S_SORT_J;
        end else begin
          wr_data   = key_r;
          i_nxt     = i_r + CW'(1);
          state_nxt = S_SORT_I;
        end
      end
      S_SORT_END: begin
        live_nxt  = CW'(({1'b0, live_r} + (CW+1)'(1)) >> 1);
        stage_nxt = stage_r + STAGE_W'(1);
        state_nxt = S_POS_GO;
      end
      S_POS_GO: begin
        div_start = 1'b1;
        div_a     = calls_r;
        div_b     = 32'(live_r);
        state_nxt = S_POS;
      end
      S_POS: begin
        if (div_done) begin
          rd_addr    = IW'(div_rem);
          lpos_nxt   = IW'(div_rem);
          calls_nxt  = calls_r + 32'd1;
          handed_nxt = 1'b1;
          state_nxt  = S_POS_RD;
        end
      end
      S_POS_RD: begin
        res_nxt   = '{ST_OK, rd_data_r[EW-1:SCORE_BITS], rd_sc32};
        state_nxt = S_OUT;
      end
      S_UPD_RD: begin
        // keep the entry on the read port for the write-back cycle
        rd_addr   = lpos_r;
        state_nxt = S_UPD_WR;
      end
      S_UPD_WR: begin
        wr_en     = 1'b1;
        wr_addr   = lpos_r;
        wr_data   = {rd_data_r[EW-1:SCORE_BITS], in_sc};
        res_nxt   = '{ST_OK, rd_data_r[EW-1:SCORE_BITS], in_sc32};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt     = 1'b1;
          ores_nxt   = res_r;
          ostage_nxt = stage_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ov_r      <= 1'b0;
      end_r     <= '0;
      iv_r      <= 16'd1;
      live_r    <= '0;
      calls_r   <= '0;
      samp_r    <= '0;
      start_r   <= '0;
      len_r     <= '0;
      stage_r   <= '0;
      started_r <= 1'b0;
      handed_r  <= 1'b0;
      lpos_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      ov_r      <= ov_nxt;
      end_r     <= end_nxt;
      iv_r      <= iv_nxt;
      live_r    <= live_nxt;
      calls_r   <= calls_nxt;
      samp_r    <= samp_nxt;
      start_r   <= start_nxt;
      len_r     <= len_nxt;
      stage_r   <= stage_nxt;
      started_r <= started_nxt;
      handed_r  <= handed_nxt;
      lpos_r    <= lpos_nxt;
    end
    cur_r    <= cur_nxt;
    res_r    <= res_nxt;
    ores_r   <= ores_nxt;
    ostage_r <= ostage_nxt;
    x_r      <= x_nxt;
    n_r      <= n_nxt;
    prod_r   <= prod_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    key_r    <= key_nxt;
  end

endmodule

[tb/shs_checker.sv]
`timescale 1ns / 100ps
// checker for the successive halving scheduler: predicts every reply and compares it
module shs_checker import shs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // score[31:0], now_time[63:32]
  input  logic [1:0]  in_tuser,   // action[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // status[1:0], entry_id[11:2], entry_score[43:12], stage[47:44]
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int TABLE_DEPTH = 1024;

  typedef struct packed {
    status_t            status;
    logic [9:0]         id;
    logic signed [31:0] score;
    logic [3:0]         stage;
  } reply_t;

  reply_t             replies_due[$];
  logic signed [31:0] score_tab[TABLE_DEPTH];
  logic [9:0]         handle_tab[TABLE_DEPTH];
  int unsigned        live;
  logic [31:0]        calls, seen_time, t_start, stage_len, end_reg;
  logic [15:0]        interval;
  logic [3:0]         stage_no;
  bit                 started, handed;
  int unsigned        last_pos;

  task report(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t: reply %s mismatch: got %0h, expected %0h", $time, field, got, want);
    fail_count++;
  endtask

  // insertion sort by ascending score, ties keep their table order, then keep the lower-scoring half
  function void prune_table();
    int unsigned        i, j;
    logic signed [31:0] s;
    logic [9:0]         h;
    for (i = 1; i < live; i++) begin
      s = score_tab[i];
      h = handle_tab[i];
      j = i;
      while (j > 0 && score_tab[j-1] > s) begin
        score_tab[j]  = score_tab[j-1];
        handle_tab[j] = handle_tab[j-1];
        j--;
      end
      score_tab[j]  = s;
      handle_tab[j] = h;
    end
    live = (live + 1) / 2;
  endfunction

  function reply_t predict_reply(cmd_e_t act, logic signed [31:0] s, logic [31:0] now);
    reply_t      r;
    int unsigned x, n, pos;
    logic [31:0] iv;
    logic [63:0] bound;
    r = '{ST_REJECT, 10'd0, 32'sd0, 4'd0};
    case (act)
      ACT_LOAD: begin
        if (started) begin
          r.status = ST_REJECT;
        end else if (live >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          score_tab[live]  = s;
          handle_tab[live] = live[9:0];
          live++;
          r = '{ST_OK, handle_tab[live-1], s, 4'd0};
        end
      end
      ACT_START: begin
        if (!started && live != 0) begin
          x = 1;
          n = 1;
          while (x < live) begin
            x = x * 2;
            n++;
          end
          t_start   = now;
          seen_time = now;
          stage_len = (end_reg > now) ? (end_reg - now) / n : 32'd0;
          started   = 1;
          r.status  = ST_OK;
        end
      end
      ACT_NEXT: begin
        if (started) begin
          iv = (interval == 0) ? 32'd1 : {16'd0, interval};
          if (calls % iv == 0) seen_time = now;
          if (seen_time >= end_reg) begin
            handed = 0;
            r = '{ST_FINISHED, handle_tab[0], 32'sd0, 4'd0};
          end else begin
            if (stage_no < STAGE_MAX) begin
              bound = {32'd0, t_start} + {32'd0, stage_len} * ({60'd0, stage_no} + 64'd1);
              if ({32'd0, seen_time} >= bound) begin
                prune_table();
                stage_no++;
              end
            end
            pos = calls % live;
            calls++;
            last_pos = pos;
            handed   = 1;
            r = '{ST_OK, handle_tab[pos], score_tab[pos], 4'd0};
          end
        end
      end
      default: begin
        if (handed && last_pos < live) begin
          score_tab[last_pos] = s;
          r = '{ST_OK, handle_tab[last_pos], s, 4'd0};
        end
      end
    endcase
    r.stage = stage_no;
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t got, want;
    if (!rst_n) begin
      replies_due.delete();
      live = 0; calls = 0; seen_time = 0; t_start = 0; stage_len = 0;
      stage_no = 0; started = 0; handed = 0; last_pos = 0;
      end_reg = 0; interval = 1;
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_END_TIME) end_reg = cfg_data;
        else interval = cfg_data[15:0];
      end
      if (in_tvalid && in_tready)
        replies_due.insert(replies_due.size(),
                           predict_reply(cmd_e_t'(in_tuser), in_tdata[31:0], in_tdata[63:32]));
      if (out_tvalid && out_tready) begin
        got = {out_tdata[1:0], out_tdata[11:2], out_tdata[43:12], out_tdata[47:44]};
        if (replies_due.size() == 0) begin
          $display("%0t: reply with no request waiting: %0h", $time, out_tdata);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (got.status != want.status) report("status", got.status, want.status);
          if (got.id != want.id) report("entry_id", got.id, want.id);
          if (got.score != want.score) report("entry_score", got.score, want.score);
          if (got.stage != want.stage) report("stage", got.stage, want.stage);
        end
      end
    end
    pending = replies_due.size();
  end

endmodule

[tb/tb_successive_halving_scheduler.sv]
`timescale 1ns / 100ps
// testbench top for the successive halving scheduler: stimulus, idling and verdict
module tb_successive_halving_scheduler;
  import shs_pkg::*;

  localparam int QUIET_LIMIT = 5000000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES = 400;      // long receiver hold-off
  localparam logic [31:0] T_START = 32'h1000_0000;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [63:0] in_tdata;   // score[31:0], now_time[63:32]
  logic [1:0]  in_tuser;   // action[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;  // status[1:0], entry_id[11:2], entry_score[43:12], stage[47:44]
  logic        cfg_we, cfg_idx;
  logic [31:0] cfg_data;
  int          fail_count, pending;

  int send_idle, recv_idle;  // idle chance in percent
  bit hold_arm = 1'b0;
  bit held = 1'b0;
  int hold_left = 0;
  int quiet = 0;

  successive_halving_scheduler uut (.*);

  shs_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver side: random stalls, plus one long hold-off counted here
  always @(negedge clk) begin
    if (hold_arm && !held) begin
      held = 1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // one request, with random gaps ahead of it; called at a falling edge
  task send_request(cmd_e_t act, logic [31:0] score, logic [31:0] now);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {now, score};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // sender pause until every reply is back
  task drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task write_reg(cfg_idx_t idx, logic [31:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int          load_scores[$];
    int          r, v;
    logic [31:0] t_now;
    rst_n = 0; in_tvalid = 0; in_tdata = 0; in_tuser = 0;
    cfg_we = 0; cfg_idx = 0; cfg_data = 0;
    send_idle = 11; recv_idle = 83;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_reg(CFG_END_TIME, 32'd0);
    write_reg(CFG_INTERVAL, 32'd1);

    // rejects before anything is loaded
    send_request(ACT_NEXT, $urandom, $urandom);
    send_request(ACT_START, $urandom, $urandom);
    send_request(ACT_UPDATE, $urandom, $urandom);

    // load part of the table; scores sorted so the first prune stays cheap,
    // with both extremes and a few ties
    load_scores.insert(load_scores.size(), 32'sh8000_0000);
    load_scores.insert(load_scores.size(), 32'sh7fff_ffff);
    for (int i = 0; i < 90; i++) load_scores.insert(load_scores.size(), $urandom);
    for (int i = 0; i < 4; i++) load_scores.insert(load_scores.size(), load_scores[i + 2]);
    load_scores.sort();
    foreach (load_scores[i]) send_request(ACT_LOAD, load_scores[i], $urandom);
    drain();

    write_reg(CFG_END_TIME, 32'hFFFF_FFFF);
    send_request(ACT_START, $urandom, T_START);
    send_request(ACT_START, $urandom, $urandom);     // already running
    send_request(ACT_LOAD, $urandom, $urandom);      // load after start
    send_request(ACT_NEXT, $urandom, 32'hFFFF_FFFF); // finished reply
    send_request(ACT_UPDATE, $urandom, $urandom);    // update after finished
    send_request(ACT_NEXT, $urandom, T_START);
    send_request(ACT_UPDATE, 32'h7fff_ffff, $urandom);
    send_request(ACT_NEXT, $urandom, 32'd0);         // time before start
    send_request(ACT_UPDATE, 32'h8000_0000, $urandom);

    t_now = T_START;
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      if (phase == 1) begin
        send_idle = 83; recv_idle = 11;
        write_reg(CFG_INTERVAL, 32'd3);
      end else if (phase == 2) begin
        send_idle = 0; recv_idle = 0;
        write_reg(CFG_INTERVAL, 32'd65535);
        write_reg(CFG_END_TIME, 32'hC000_0000);
        hold_arm = 1;  // receiver stops for a while, input side must back up
      end
      for (int k = 0; k < 115; k++) begin
        r = $urandom_range(99);
        v = $urandom;
        if (r < 55) begin
          if ($urandom_range(99) < 6) begin
            send_request(ACT_NEXT, v, $urandom);
          end else begin
            send_request(ACT_NEXT, v, t_now);
            t_now = t_now + 32'h00C0_0000 + $urandom_range(255);
          end
        end else if (r < 90) begin
          send_request(ACT_UPDATE, v, $urandom);
        end else if (r < 95) begin
          send_request(ACT_LOAD, v, $urandom);
        end else begin
          send_request(ACT_START, v, $urandom);
        end
      end
    end

    drain();
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
